@@ design/bdc_pkg.sv @@
// Package: shared constants and types for the button debounce and combo decoder.
`default_nettype none
package bdc_pkg;

  localparam int unsigned BUTTONS     = 8;
  localparam int unsigned SLOTS       = 5;
  localparam int unsigned MODE_SINGLE = 6;
  localparam int unsigned MODE_RAPID  = 7;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned SLOT_W      = 4;

  localparam logic [PERIOD_W-1:0]      PERIOD_RESET = 16'd20;
  localparam logic signed [SLOT_W-1:0] NO_SLOT      = -4'sd1;

  typedef logic [BUTTONS-1:0]      btn_mask_t;
  typedef logic [TIME_W-1:0]       ms_time_t;
  typedef logic signed [SLOT_W-1:0] slot_t;

  typedef struct packed {
    btn_mask_t press_edges;
    btn_mask_t stable_mask;
    slot_t     record_slot;
    slot_t     playback_slot;
    slot_t     mode_slot;
    logic      mode_rapid;
    ms_time_t  modifier_press_time;
  } bdc_result_t;

endpackage
`default_nettype wire

@@ design/bdc_if.sv @@
// Interfaces: poll input, result output and period write channels.
`default_nettype none
interface bdc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  raw_levels;
  logic [31:0] now_ms;

  modport source (output valid, output raw_levels, output now_ms, input ready);
  modport sink   (input valid, input raw_levels, input now_ms, output ready);
endinterface

interface bdc_out_if;
  logic              valid;
  logic              ready;
  logic [7:0]        press_edges;
  logic [7:0]        stable_mask;
  logic signed [3:0] record_slot;
  logic signed [3:0] playback_slot;
  logic signed [3:0] mode_slot;
  logic              mode_rapid;
  logic [31:0]       modifier_press_time;

  modport source (output valid, output press_edges, output stable_mask,
                  output record_slot, output playback_slot, output mode_slot,
                  output mode_rapid, output modifier_press_time, input ready);
  modport sink   (input valid, input press_edges, input stable_mask,
                  input record_slot, input playback_slot, input mode_slot,
                  input mode_rapid, input modifier_press_time, output ready);
endinterface

interface bdc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] debounce_period;

  modport source (output valid, output debounce_period, input ready);
  modport sink   (input valid, input debounce_period, output ready);
endinterface
`default_nettype wire

@@ design/button_debounce_combo_decoder_top.sv @@
// Top level: poll register, debounce and combo logic, result register.
//
// Each transfer on in_chan is one poll: eight active-low button levels and a
// millisecond timestamp. Each poll yields exactly one result on out_chan,
// carrying press and stable masks, record/playback/mode slot decodes (-1 for
// none) and the time of button 0's latest debounced press.
// cfg_chan writes the debounce period in ms; cfg_chan.ready is always high.
// Write it only while no poll is in flight.
// Each poll passes through the poll register and then the result register.
// Throughput: one poll per cycle while out_chan takes each result. The
// poll register feeds the debounce timers and decoders combinationally and
// the result register holds the outcome, so both stages advance together
// whenever the result is taken.
// When out_chan stalls, the result register and the poll register hold and
// in_chan.ready drops once both are full; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all button state, the modifier time
// and both stages, and sets the period to 20 ms.
`default_nettype none
module button_debounce_combo_decoder_top
  import bdc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  bdc_in_if.sink       in_chan,
  bdc_out_if.source    out_chan,
  bdc_cfg_if.sink      cfg_chan
);

  logic [PERIOD_W-1:0] period_r;
  logic                poll_valid_r;
  btn_mask_t           poll_raw_r;
  ms_time_t            poll_now_r;
  logic                out_valid_r;
  bdc_result_t         out_r;

  logic        out_adv;
  logic        poll_fire;
  btn_mask_t   pressed;
  btn_mask_t   stable;
  bdc_result_t result;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_chan.valid) begin
      period_r <= cfg_chan.debounce_period;
    end
  end

  // result register frees up when empty or being taken
  assign out_adv        = !out_valid_r || out_chan.ready;
  assign poll_fire      = poll_valid_r && out_adv;
  assign in_chan.ready  = !poll_valid_r || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      poll_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      poll_raw_r <= in_chan.raw_levels;
      poll_now_r <= in_chan.now_ms;
    end
  end

  bdc_debounce u_debounce (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (poll_fire),
    .raw_levels (poll_raw_r),
    .now_ms     (poll_now_r),
    .period     (period_r),
    .pressed    (pressed),
    .stable     (stable)
  );

  bdc_combo u_combo (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (poll_fire),
    .pressed (pressed),
    .stable  (stable),
    .now_ms  (poll_now_r),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= poll_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (poll_fire) begin
      out_r <= result;
    end
  end

  assign out_chan.valid               = out_valid_r;
  assign out_chan.press_edges         = out_r.press_edges;
  assign out_chan.stable_mask         = out_r.stable_mask;
  assign out_chan.record_slot         = out_r.record_slot;
  assign out_chan.playback_slot       = out_r.playback_slot;
  assign out_chan.mode_slot           = out_r.mode_slot;
  assign out_chan.mode_rapid          = out_r.mode_rapid;
  assign out_chan.modifier_press_time = out_r.modifier_press_time;

  a_rapid_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.mode_rapid |-> out_r.mode_slot != NO_SLOT)
    else $error("mode_rapid set without a mode slot");

  a_record_xor_playback: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.record_slot == NO_SLOT) || (out_r.playback_slot == NO_SLOT))
    else $error("record and playback slots both decoded");

  a_pressed_is_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.press_edges & ~out_r.stable_mask) == '0)
    else $error("press reported on a button that is not stably held");

  a_poll_lands: assert property (@(posedge clk) disable iff (!rst_n)
    poll_fire |=> out_valid_r)
    else $error("processed poll did not reach the result register");

endmodule
`default_nettype wire

@@ design/bdc_debounce.sv @@
// Per-button debounce timers, stable levels and press-edge detection.
`default_nettype none
module bdc_debounce
  import bdc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire btn_mask_t           raw_levels,
  input  wire ms_time_t            now_ms,
  input  wire logic [PERIOD_W-1:0] period,
  output btn_mask_t                pressed,
  output btn_mask_t                stable
);

  btn_mask_t last_raw_r, last_raw_nxt;
  btn_mask_t debounced_r, debounced_nxt;
  ms_time_t  change_time_r [BUTTONS];
  ms_time_t  change_time_nxt [BUTTONS];

  always_comb begin
    ms_time_t elapsed;
    elapsed = '0;
    for (int i = 0; i < BUTTONS; i++) begin
      last_raw_nxt[i] = ~raw_levels[i];
      // restart the timer on any raw change
      change_time_nxt[i] = (last_raw_nxt[i] != last_raw_r[i]) ? now_ms : change_time_r[i];
      elapsed = now_ms - change_time_nxt[i];
      if (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, period}) begin
        debounced_nxt[i] = last_raw_nxt[i];
      end else begin
        debounced_nxt[i] = debounced_r[i];
      end
    end
  end

  assign pressed = debounced_nxt & ~debounced_r;
  assign stable  = debounced_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r  <= '0;
      debounced_r <= '0;
      for (int i = 0; i < BUTTONS; i++) begin
        change_time_r[i] <= '0;
      end
    end else if (en) begin
      last_raw_r  <= last_raw_nxt;
      debounced_r <= debounced_nxt;
      for (int i = 0; i < BUTTONS; i++) begin
        change_time_r[i] <= change_time_nxt[i];
      end
    end
  end

endmodule
`default_nettype wire

@@ design/bdc_combo.sv @@
// Slot decodes for record, playback and mode, plus modifier press time.
`default_nettype none
module bdc_combo
  import bdc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire btn_mask_t pressed,
  input  wire btn_mask_t stable,
  input  wire ms_time_t  now_ms,
  output bdc_result_t    result
);

  ms_time_t modifier_time_r, modifier_time_nxt;
  slot_t    slot;

  // lowest newly pressed slot button wins: scan downward so it is written last
  always_comb begin
    slot = NO_SLOT;
    for (int k = SLOTS; k >= 1; k--) begin
      if (k < BUTTONS && pressed[k]) begin
        slot = SLOT_W'(k - 1);
      end
    end
  end

  assign modifier_time_nxt = pressed[0] ? now_ms : modifier_time_r;

  always_comb begin
    result.press_edges         = pressed;
    result.stable_mask         = stable;
    result.record_slot         = stable[0] ? slot : NO_SLOT;
    result.playback_slot       = stable[0] ? NO_SLOT : slot;
    result.mode_slot           = NO_SLOT;
    result.mode_rapid          = 1'b0;
    result.modifier_press_time = modifier_time_nxt;
    if (slot != NO_SLOT) begin
      if (stable[MODE_SINGLE]) begin
        result.mode_slot = slot;
      end else if (stable[MODE_RAPID]) begin
        result.mode_slot  = slot;
        result.mode_rapid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modifier_time_r <= '0;
    end else if (en) begin
      modifier_time_r <= modifier_time_nxt;
    end
  end

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Testbench for the button debounce and combo decoder: directed and random polls.
`timescale 1ns / 1ps

module testbench;
  import bdc_pkg::*;

  class debounce_scoreboard;
    logic [PERIOD_W-1:0] period;
    btn_mask_t           raw_held;
    btn_mask_t           stable;
    ms_time_t            change_ms [BUTTONS];
    ms_time_t            modifier_ms;
    bdc_result_t         expected_results [$];
    int unsigned         errors;

    function new();
      period      = PERIOD_RESET;
      raw_held    = '0;
      stable      = '0;
      modifier_ms = '0;
      errors      = 0;
      foreach (change_ms[i]) change_ms[i] = '0;
    endfunction

    // Predict the result of one accepted poll and queue it.
    function void note_poll(btn_mask_t raw, ms_time_t now_ms);
      btn_mask_t   fresh;
      slot_t       first;
      ms_time_t    elapsed;
      bdc_result_t r;
      int          i;
      fresh = '0;
      for (i = 0; i < BUTTONS; i++) begin
        if (!raw[i] != raw_held[i]) begin
          raw_held[i]  = !raw[i];
          change_ms[i] = now_ms;
        end
        elapsed = now_ms - change_ms[i];
        if (elapsed >= ms_time_t'(period)) begin
          if (raw_held[i] && !stable[i]) fresh[i] = 1'b1;
          stable[i] = raw_held[i];
        end
      end
      if (fresh[0]) modifier_ms = now_ms;
      // lowest slot button wins
      first = NO_SLOT;
      for (i = SLOTS; i >= 1; i--) begin
        if (fresh[i]) first = slot_t'(i - 1);
      end
      r.press_edges         = fresh;
      r.stable_mask         = stable;
      r.record_slot         = stable[0] ? first : NO_SLOT;
      r.playback_slot       = stable[0] ? NO_SLOT : first;
      r.mode_slot           = NO_SLOT;
      r.mode_rapid          = 1'b0;
      if (first != NO_SLOT) begin
        if (stable[MODE_SINGLE]) begin
          r.mode_slot = first;
        end else if (stable[MODE_RAPID]) begin
          r.mode_slot  = first;
          r.mode_rapid = 1'b1;
        end
      end
      r.modifier_press_time = modifier_ms;
      expected_results.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] %s", $time, msg);
      errors++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("%s: got %h, expected %h", name, got, want));
    endtask

    task check_result(bdc_result_t got);
      bdc_result_t want;
      if (expected_results.size() == 0) begin
        report("result transfer with no poll outstanding");
      end else begin
        want = expected_results.pop_front();
        compare_field("press_edges", 32'(got.press_edges), 32'(want.press_edges));
        compare_field("stable_mask", 32'(got.stable_mask), 32'(want.stable_mask));
        compare_field("record_slot", 32'(got.record_slot), 32'(want.record_slot));
        compare_field("playback_slot", 32'(got.playback_slot), 32'(want.playback_slot));
        compare_field("mode_slot", 32'(got.mode_slot), 32'(want.mode_slot));
        compare_field("mode_rapid", 32'(got.mode_rapid), 32'(want.mode_rapid));
        compare_field("modifier_press_time", got.modifier_press_time,
                      want.modifier_press_time);
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  bit   sink_steady = 1'b0;

  bdc_in_if  in_chan ();
  bdc_out_if out_chan ();
  bdc_cfg_if cfg_chan ();

  debounce_scoreboard sb = new();
  bdc_result_t        seen;

  button_debounce_combo_decoder_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned idle_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls, none while a steady stretch runs.
  initial begin
    int unsigned hold;
    out_chan.ready <= 1'b0;
    forever begin
      if (sink_steady) begin
        out_chan.ready <= 1'b1;
        @(posedge clk);
      end else begin
        hold = idle_gap();
        if (hold != 0) begin
          out_chan.ready <= 1'b0;
          repeat (hold) @(posedge clk);
        end
        out_chan.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      seen.press_edges         = out_chan.press_edges;
      seen.stable_mask         = out_chan.stable_mask;
      seen.record_slot         = out_chan.record_slot;
      seen.playback_slot       = out_chan.playback_slot;
      seen.mode_slot           = out_chan.mode_slot;
      seen.mode_rapid          = out_chan.mode_rapid;
      seen.modifier_press_time = out_chan.modifier_press_time;
      sb.check_result(seen);
    end
  end

  task automatic send_poll(btn_mask_t raw, ms_time_t now_ms, bit steady_run);
    int unsigned gap;
    gap = steady_run ? 0 : idle_gap();
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.raw_levels <= raw;
    in_chan.now_ms     <= now_ms;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_poll(raw, now_ms);
  endtask

  // Hold off the sender until every queued result has come back.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_results.size() != 0);
  endtask

  task automatic write_period(logic [PERIOD_W-1:0] value);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_chan.valid           <= 1'b1;
    cfg_chan.debounce_period <= value;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    sb.period = value;
  endtask

  // Button sequences: modifiers held for stretches, slot buttons pressed
  // more often, with bounce noise and occasional time jumps.
  task automatic run_polls(int unsigned count, bit steady_run);
    btn_mask_t   intent;
    btn_mask_t   slot_bits;
    btn_mask_t   raw;
    ms_time_t    now_ms;
    int unsigned span;
    int unsigned pick;
    int unsigned pause_at;
    int unsigned n;
    intent      = '0;
    now_ms      = $urandom();
    span        = 32'(sb.period);
    pause_at    = $urandom_range(count / 4, 3 * count / 4);
    sink_steady = steady_run;
    for (n = 0; n < count; n++) begin
      if (n == pause_at) drain_results();
      if ($urandom_range(0, 99) < 8) begin
        intent[0]           = 1'($urandom_range(0, 1));
        intent[MODE_SINGLE] = 1'($urandom_range(0, 1));
        intent[MODE_RAPID]  = 1'($urandom_range(0, 1));
      end
      if ($urandom_range(0, 99) < 25) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) slot_bits = '0;
        else if (pick < 8) slot_bits = btn_mask_t'(1) << $urandom_range(1, SLOTS);
        else slot_bits = btn_mask_t'($urandom()) & 8'h3E;
        intent = (intent & ~8'h3E) | slot_bits;
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) now_ms += $urandom_range(0, 3);
      else if (pick < 60) now_ms += $urandom_range(1, span / 2 + 1);
      else if (pick < 80) now_ms += $urandom_range(span, span + 2) - 1;
      else if (pick < 95) now_ms += $urandom_range(span + 1, 2 * span + 2);
      else now_ms = $urandom();
      raw = ~intent;
      if ($urandom_range(0, 99) < 10) raw ^= btn_mask_t'($urandom());
      send_poll(raw, now_ms, steady_run);
    end
    sink_steady = 1'b0;
  endtask

  initial begin
    int unsigned phase_periods [8];
    int          p;
    phase_periods = '{20, 1, 0, 7, 65535, 3, 30, 12};
    rst_n                    <= 1'b0;
    in_chan.valid            <= 1'b0;
    in_chan.raw_levels       <= 8'hFF;
    in_chan.now_ms           <= '0;
    cfg_chan.valid           <= 1'b0;
    cfg_chan.debounce_period <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset period: button 0 settles after 20 ms
    send_poll(8'hFF, 32'd0, 1'b0);
    send_poll(8'hFE, 32'd5, 1'b0);
    send_poll(8'hFE, 32'd24, 1'b0);
    send_poll(8'hFE, 32'd25, 1'b0);

    // zero period: levels follow on the same poll
    write_period(16'd0);
    send_poll(8'h00, 32'd100, 1'b0);
    send_poll(8'hFF, 32'd101, 1'b0);
    send_poll(8'h7F, 32'd102, 1'b0);
    send_poll(8'h77, 32'd103, 1'b0);
    send_poll(8'hBF, 32'd104, 1'b0);
    send_poll(8'h9F, 32'd105, 1'b0);
    send_poll(8'hFF, 32'd106, 1'b0);
    send_poll(8'hC1, 32'd107, 1'b0);
    send_poll(8'hC0, 32'd108, 1'b0);
    send_poll(8'hFF, 32'hFFFF_FFFF, 1'b0);
    send_poll(8'hFE, 32'h0000_0000, 1'b0);
    send_poll(8'h3C, 32'h8000_0000, 1'b0);
    send_poll(8'hFF, 32'h7FFF_FFFF, 1'b0);

    // longest period, then time stepping backwards
    write_period(16'hFFFF);
    send_poll(8'hFD, 32'd1000, 1'b0);
    send_poll(8'hFD, 32'd1000 + 32'd65534, 1'b0);
    send_poll(8'hFD, 32'd1000 + 32'd65535, 1'b0);
    send_poll(8'hFF, 32'd500, 1'b0);
    send_poll(8'hFF, 32'd499, 1'b0);

    for (p = 0; p < 8; p++) begin
      write_period(phase_periods[p][PERIOD_W-1:0]);
      run_polls(82, p % 3 == 2);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

@@ files.f @@
design/bdc_pkg.sv
design/bdc_if.sv
design/bdc_debounce.sv
design/bdc_combo.sv
design/button_debounce_combo_decoder_top.sv
bench/testbench.sv
